// ===== rtl/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dsfe_pkg
// types and constants shared by the escape-stuffed frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package dsfe_pkg;

    localparam int BYTE_W = 8;

    // register map, word index taken from paddr[3:2]
    localparam logic [1:0] REG_ESCAPE  = 2'd0;
    localparam logic [1:0] REG_START   = 2'd1;
    localparam logic [1:0] REG_END     = 2'd2;
    localparam logic [1:0] REG_COMMAND = 2'd3;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'h10;
    localparam logic [BYTE_W-1:0] START_RESET   = 8'h02;
    localparam logic [BYTE_W-1:0] END_RESET     = 8'h03;
    localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'hA1;

    typedef struct packed {
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] command_code;
    } cfg_t;

    // one classified payload word, as queued between front and back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] checksum;
        logic              first_of_frame;
        logic              last_of_frame;
        logic              is_escape;
    } desc_t;

    // position of the back end within the bytes of one queued word
    typedef enum logic [3:0] {
        SEQ_NEW,
        SEQ_OPEN,
        SEQ_START,
        SEQ_CMD,
        SEQ_LEN,
        SEQ_DUP,
        SEQ_DATA,
        SEQ_CHK,
        SEQ_CLOSE,
        SEQ_END
    } seq_t;

endpackage

`default_nettype wire

// ===== rtl/dsfe_if.sv =====
// ----------------------------------------------------------------------------
// dsfe channel interfaces
// valid/ready channels for payload words in and framed bytes out
// ----------------------------------------------------------------------------
`default_nettype none

interface dsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] payload_length;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (output valid, output data_byte, output payload_length,
                    output first_of_frame, output last_of_frame, input ready);
    modport sink   (input valid, input data_byte, input payload_length,
                    input first_of_frame, input last_of_frame, output ready);
endinterface

interface dsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, output out_byte, output last_of_run,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/dle_stuffed_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// dle_stuffed_frame_encoder_core
// escape-stuffed start/end framer with command, length and checksum
// ----------------------------------------------------------------------------
//  channel   dir  handshake      content
//  in_ch     in   valid/ready    data_byte, payload_length, first/last_of_frame
//  out_ch    out  valid/ready    out_byte, last_of_run, frame_end
//  apb       in   psel/penable   four 8-bit registers at 0x0, 0x4, 0x8, 0xc
//
//  the back sequencer emits one byte per cycle while a word waits and out_ch
//  takes bytes: a word gives 1 byte, 2 if escaped, plus 4 header, 3 trailer
//  the front takes a word per cycle while the word queue has room
//  out_ch stalls hold the output register; the queue absorbs input meanwhile
//  reset clears the running sum, the queue and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module dle_stuffed_frame_encoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    dsfe_in_if.sink     in_ch,
    dsfe_out_if.source  out_ch
);

    dsfe_pkg::cfg_t  cfg_reg;
    dsfe_pkg::cfg_t  cfg_next;
    dsfe_pkg::desc_t push_desc;
    dsfe_pkg::desc_t head_desc;

    logic       push_valid;
    logic       push_ready;
    logic       head_valid;
    logic       pop;
    logic       wr_en;
    logic [1:0] word_idx;
    logic [7:0] rd_byte;

    assign pready   = 1'b1;
    assign word_idx = paddr[3:2];
    assign wr_en    = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (word_idx)
                dsfe_pkg::REG_ESCAPE:  cfg_next.escape_byte  = pwdata[7:0];
                dsfe_pkg::REG_START:   cfg_next.start_byte   = pwdata[7:0];
                dsfe_pkg::REG_END:     cfg_next.end_byte     = pwdata[7:0];
                dsfe_pkg::REG_COMMAND: cfg_next.command_code = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (word_idx)
            dsfe_pkg::REG_ESCAPE:  rd_byte = cfg_reg.escape_byte;
            dsfe_pkg::REG_START:   rd_byte = cfg_reg.start_byte;
            dsfe_pkg::REG_END:     rd_byte = cfg_reg.end_byte;
            dsfe_pkg::REG_COMMAND: rd_byte = cfg_reg.command_code;
            default:               rd_byte = 8'd0;
        endcase
        prdata = {24'd0, rd_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_byte  <= dsfe_pkg::ESCAPE_RESET;
            cfg_reg.start_byte   <= dsfe_pkg::START_RESET;
            cfg_reg.end_byte     <= dsfe_pkg::END_RESET;
            cfg_reg.command_code <= dsfe_pkg::COMMAND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dsfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    dsfe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop)
    );

    dsfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/dsfe_front.sv =====
// ----------------------------------------------------------------------------
// dsfe_front
// accepts payload words, keeps the running sum and classifies each word
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_front
(
    input  wire                clk,
    input  wire                rst_n,
    dsfe_in_if.sink            in_ch,
    input  dsfe_pkg::cfg_t     cfg,
    output logic               push_valid,
    input  wire                push_ready,
    output dsfe_pkg::desc_t    push_desc
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] base_sum;
    logic [7:0] new_sum;
    logic       accept;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign push_valid  = in_ch.valid;

    // header seeds the sum with command code plus length
    assign base_sum = in_ch.first_of_frame ? (cfg.command_code + in_ch.payload_length)
                                           : sum_reg;
    assign new_sum  = base_sum + in_ch.data_byte;

    always_comb
    begin
        push_desc.data_byte      = in_ch.data_byte;
        push_desc.payload_length = in_ch.payload_length;
        push_desc.checksum       = 8'd0 - new_sum;
        push_desc.first_of_frame = in_ch.first_of_frame;
        push_desc.last_of_frame  = in_ch.last_of_frame;
        push_desc.is_escape      = (in_ch.data_byte == cfg.escape_byte);
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = in_ch.last_of_frame ? 8'd0 : new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'd0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsfe_queue.sv =====
// ----------------------------------------------------------------------------
// dsfe_queue
// short first-in first-out queue of classified words
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push_valid,
    output logic               push_ready,
    input  dsfe_pkg::desc_t    push_desc,
    output logic               head_valid,
    output dsfe_pkg::desc_t    head_desc,
    input  wire                pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dsfe_pkg::desc_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    property p_no_pop_when_empty;
        @(posedge clk) disable iff (!rst_n) pop |-> head_valid;
    endproperty
    a_no_pop_when_empty: assert property (p_no_pop_when_empty)
        else $error("queue popped while empty");

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("queue count beyond depth");

    property p_push_grows;
        @(posedge clk) disable iff (!rst_n)
            (do_push && !pop) |=> (count_reg == $past(count_reg) + 1'b1);
    endproperty
    a_push_grows: assert property (p_push_grows)
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== rtl/dsfe_back.sv =====
// ----------------------------------------------------------------------------
// dsfe_back
// walks the frame bytes of each queued word into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module dsfe_back
(
    input  wire                clk,
    input  wire                rst_n,
    input  dsfe_pkg::cfg_t     cfg,
    input  wire                head_valid,
    input  dsfe_pkg::desc_t    head_desc,
    output logic               pop,
    dsfe_out_if.source         out_ch
);

    dsfe_pkg::seq_t state_reg, state_next;
    dsfe_pkg::seq_t cur;
    dsfe_pkg::seq_t succ;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       run_reg,   run_next;
    logic       end_reg,   end_next;
    logic       step;
    logic       final_pos;

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.last_of_run = run_reg;
    assign out_ch.frame_end   = end_reg;

    // output register frees up when empty or being taken
    assign step = head_valid && (!valid_reg || out_ch.ready);

    always_comb
    begin
        // a fresh word picks its entry point from its flags
        if (state_reg == dsfe_pkg::SEQ_NEW)
        begin
            if (head_desc.first_of_frame)
                cur = dsfe_pkg::SEQ_OPEN;
            else if (head_desc.is_escape)
                cur = dsfe_pkg::SEQ_DUP;
            else
                cur = dsfe_pkg::SEQ_DATA;
        end
        else
        begin
            cur = state_reg;
        end

        unique case (cur)
            dsfe_pkg::SEQ_OPEN:  succ = dsfe_pkg::SEQ_START;
            dsfe_pkg::SEQ_START: succ = dsfe_pkg::SEQ_CMD;
            dsfe_pkg::SEQ_CMD:   succ = dsfe_pkg::SEQ_LEN;
            dsfe_pkg::SEQ_LEN:   succ = head_desc.is_escape ? dsfe_pkg::SEQ_DUP
                                                            : dsfe_pkg::SEQ_DATA;
            dsfe_pkg::SEQ_DUP:   succ = dsfe_pkg::SEQ_DATA;
            dsfe_pkg::SEQ_DATA:  succ = dsfe_pkg::SEQ_CHK;
            dsfe_pkg::SEQ_CHK:   succ = dsfe_pkg::SEQ_CLOSE;
            dsfe_pkg::SEQ_CLOSE: succ = dsfe_pkg::SEQ_END;
            default:             succ = dsfe_pkg::SEQ_NEW;
        endcase

        unique case (cur)
            dsfe_pkg::SEQ_OPEN:  byte_next = cfg.escape_byte;
            dsfe_pkg::SEQ_START: byte_next = cfg.start_byte;
            dsfe_pkg::SEQ_CMD:   byte_next = cfg.command_code;
            dsfe_pkg::SEQ_LEN:   byte_next = head_desc.payload_length;
            dsfe_pkg::SEQ_DUP:   byte_next = cfg.escape_byte;
            dsfe_pkg::SEQ_DATA:  byte_next = head_desc.data_byte;
            dsfe_pkg::SEQ_CHK:   byte_next = head_desc.checksum;
            dsfe_pkg::SEQ_CLOSE: byte_next = cfg.escape_byte;
            default:             byte_next = cfg.end_byte;
        endcase

        final_pos = ((cur == dsfe_pkg::SEQ_DATA) && !head_desc.last_of_frame)
                    || (cur == dsfe_pkg::SEQ_END);
        run_next  = final_pos;
        end_next  = (cur == dsfe_pkg::SEQ_END);

        pop        = step && final_pos;
        state_next = state_reg;
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
            state_next = final_pos ? dsfe_pkg::SEQ_NEW : succ;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsfe_pkg::SEQ_NEW;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg <= byte_next;
            run_reg  <= run_next;
            end_reg  <= end_next;
        end
    end

    property p_mid_word_has_head;
        @(posedge clk) disable iff (!rst_n)
            (state_reg != dsfe_pkg::SEQ_NEW) |-> head_valid;
    endproperty
    a_mid_word_has_head: assert property (p_mid_word_has_head)
        else $error("sequencer mid-word with empty queue");

    property p_frame_end_closes_run;
        @(posedge clk) disable iff (!rst_n)
            (valid_reg && end_reg) |-> run_reg;
    endproperty
    a_frame_end_closes_run: assert property (p_frame_end_closes_run)
        else $error("end-of-text byte not flagged as last of run");

    property p_pop_resets_seq;
        @(posedge clk) disable iff (!rst_n) pop |=> (state_reg == dsfe_pkg::SEQ_NEW);
    endproperty
    a_pop_resets_seq: assert property (p_pop_resets_seq)
        else $error("sequencer did not return to a fresh word after pop");

endmodule

`default_nettype wire

// ===== tb/dle_stuffed_frame_encoder_core_test.sv =====
// ----------------------------------------------------------------------------
// dle_stuffed_frame_encoder_core_test
// feeds payload words through the escape-stuffed framer and checks every
// framed byte against a model kept by a small scoreboard, across several
// register settings, with random idling, stalls and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dle_stuffed_frame_encoder_core_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int SHOW_LIMIT   = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } framed_byte_t;

    // expected framed bytes, worked out from each accepted payload word
    class frame_byte_book;
        logic [7:0]   escape_byte;
        logic [7:0]   start_byte;
        logic [7:0]   end_byte;
        logic [7:0]   command_code;
        logic [7:0]   running_sum;
        framed_byte_t owed_bytes[$];
        framed_byte_t run_bytes[$];
        int           errors;
        int           shown;

        function new();
            escape_byte  = dsfe_pkg::ESCAPE_RESET;
            start_byte   = dsfe_pkg::START_RESET;
            end_byte     = dsfe_pkg::END_RESET;
            command_code = dsfe_pkg::COMMAND_RESET;
            running_sum  = 8'd0;
            errors       = 0;
            shown        = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                dsfe_pkg::REG_ESCAPE:  escape_byte  = val;
                dsfe_pkg::REG_START:   start_byte   = val;
                dsfe_pkg::REG_END:     end_byte     = val;
                dsfe_pkg::REG_COMMAND: command_code = val;
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic fe);
            framed_byte_t item;
            item.out_byte    = b;
            item.last_of_run = 1'b0;
            item.frame_end   = fe;
            run_bytes.push_back(item);
        endfunction

        function void note_word(logic [7:0] data, logic [7:0] len, logic first, logic last);
            logic [7:0] chk;
            run_bytes = {};
            if (first)
            begin
                push_byte(escape_byte, 1'b0);
                push_byte(start_byte, 1'b0);
                push_byte(command_code, 1'b0);
                push_byte(len, 1'b0);
                running_sum = command_code + len;
            end
            if (data == escape_byte)
                push_byte(escape_byte, 1'b0);
            push_byte(data, 1'b0);
            running_sum = running_sum + data;
            if (last)
            begin
                chk = 8'd0 - running_sum;
                push_byte(chk, 1'b0);
                push_byte(escape_byte, 1'b0);
                push_byte(end_byte, 1'b1);
                running_sum = 8'd0;
            end
            run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
            foreach (run_bytes[i])
                owed_bytes.push_back(run_bytes[i]);
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            if (shown < SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, field, want, got);
            shown++;
        endfunction

        function void check_byte(framed_byte_t got);
            framed_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("%0t: unexpected byte, expected none, actual %02h",
                             $time, got.out_byte);
                shown++;
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", want.out_byte, got.out_byte);
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
            if (got.frame_end !== want.frame_end)
                report("frame_end", 8'(want.frame_end), 8'(got.frame_end));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dsfe_in_if  word_in ();
    dsfe_out_if byte_out ();

    frame_byte_book book;
    int             hold_cycles;
    bit             tx_steady;
    bit             rx_steady;
    int             cycle_count;
    int             words_sent;

    dle_stuffed_frame_encoder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (word_in),
        .out_ch  (byte_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // output side: check accepted bytes, then pick next ready
    initial
    begin
        byte_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && byte_out.valid && byte_out.ready)
                book.check_byte('{byte_out.out_byte, byte_out.last_of_run,
                                  byte_out.frame_end});
            if (hold_cycles > 0)
            begin
                byte_out.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_steady)
                byte_out.ready <= 1'b1;
            else
                byte_out.ready <= ($urandom_range(99) >= 33);
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_reg(idx, val);
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [7:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== want)
            book.report("register readback", want, prdata[7:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_regs(input logic [7:0] esc, input logic [7:0] stx,
                             input logic [7:0] etx, input logic [7:0] cmd);
        apb_write(dsfe_pkg::REG_ESCAPE, esc);
        apb_write(dsfe_pkg::REG_START, stx);
        apb_write(dsfe_pkg::REG_END, etx);
        apb_write(dsfe_pkg::REG_COMMAND, cmd);
        apb_check(dsfe_pkg::REG_ESCAPE, esc);
        apb_check(dsfe_pkg::REG_START, stx);
        apb_check(dsfe_pkg::REG_END, etx);
        apb_check(dsfe_pkg::REG_COMMAND, cmd);
    endtask

    task automatic send_word(input logic [7:0] data, input logic [7:0] len,
                             input logic first, input logic last);
        if (!tx_steady && $urandom_range(99) < 33)
        begin
            word_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        word_in.valid          <= 1'b1;
        word_in.data_byte      <= data;
        word_in.payload_length <= len;
        word_in.first_of_frame <= first;
        word_in.last_of_frame  <= last;
        do @(posedge clk); while (!word_in.ready);
        book.note_word(data, len, first, last);
        words_sent++;
    endtask

    // wait until every owed byte has come out
    task automatic wait_drained();
        word_in.valid <= 1'b0;
        while (book.owed_bytes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_data();
        if ($urandom_range(99) < 20)
            return book.escape_byte;
        return 8'($urandom_range(255));
    endfunction

    // mostly whole frames with a matching length, some noise and cut-off frames
    task automatic run_words(input int count);
        int target;
        int n;
        int kind;
        logic [7:0] len;
        target = words_sent + count;
        while (words_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
                send_word(pick_data(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
                len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(n);
                for (int i = 0; i < n; i++)
                    send_word(pick_data(), len, i == 0, (i == n - 1) && (kind >= 18));
            end
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = 4'd0;
        pwdata                 = 32'd0;
        word_in.valid          = 1'b0;
        word_in.data_byte      = 8'd0;
        word_in.payload_length = 8'd0;
        word_in.first_of_frame = 1'b0;
        word_in.last_of_frame  = 1'b0;
        hold_cycles            = 0;
        tx_steady              = 1'b0;
        rx_steady              = 1'b0;
        words_sent             = 0;
        book                   = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        apb_check(dsfe_pkg::REG_ESCAPE, dsfe_pkg::ESCAPE_RESET);
        apb_check(dsfe_pkg::REG_START, dsfe_pkg::START_RESET);
        apb_check(dsfe_pkg::REG_END, dsfe_pkg::END_RESET);
        apb_check(dsfe_pkg::REG_COMMAND, dsfe_pkg::COMMAND_RESET);

        // single-word frames, plain and escaped
        send_word(8'h00, 8'd1, 1'b1, 1'b1);
        send_word(8'h10, 8'd255, 1'b1, 1'b1);
        // three-word frame with an escape in the middle
        send_word(8'hFF, 8'd3, 1'b1, 1'b0);
        send_word(8'h10, 8'd3, 1'b0, 1'b0);
        send_word(8'hAA, 8'd3, 1'b0, 1'b1);
        // words with no frame open, then a trailer without header
        send_word(8'h55, 8'h00, 1'b0, 1'b0);
        send_word(8'h10, 8'h80, 1'b0, 1'b1);
        // zero length field
        send_word(8'h01, 8'd0, 1'b1, 1'b0);
        send_word(8'hFE, 8'd0, 1'b0, 1'b1);
        // length disagrees with the word count
        send_word(8'h20, 8'd5, 1'b1, 1'b0);
        send_word(8'h30, 8'd5, 1'b0, 1'b1);
        // sum comes to zero, so checksum is zero
        send_word(8'h5E, 8'd1, 1'b1, 1'b1);
        // frame restarted while still open
        send_word(8'h11, 8'd4, 1'b1, 1'b0);
        send_word(8'h22, 8'd4, 1'b1, 1'b0);
        send_word(8'h33, 8'd4, 1'b0, 1'b1);
        send_word(8'h7F, 8'h80, 1'b1, 1'b0);
        send_word(8'h80, 8'h7F, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: load_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
                1: load_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
                6: load_regs(dsfe_pkg::ESCAPE_RESET, dsfe_pkg::START_RESET,
                             dsfe_pkg::END_RESET, dsfe_pkg::COMMAND_RESET);
                default: load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            tx_steady = (p == 1);
            rx_steady = (p == 1);
            if (p == 2)
            begin
                run_words(10);
                // long output hold-off while words keep coming
                hold_cycles = 90;
                run_words(40);
            end
            else if (p == 3)
            begin
                run_words(20);
                wait_drained();
                run_words(30);
            end
            else
                run_words(48);
            wait_drained();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.owed_bytes.size() != 0)
        begin
            book.errors++;
            $display("%0t: bytes still owed, expected 0, actual %0d",
                     $time, book.owed_bytes.size());
        end
        if (book.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dsfe_pkg.sv
rtl/dsfe_if.sv
rtl/dsfe_front.sv
rtl/dsfe_queue.sv
rtl/dsfe_back.sv
rtl/dle_stuffed_frame_encoder_core.sv
tb/dle_stuffed_frame_encoder_core_test.sv
